// ===== design/blank_and_comment_skipper_defines.svh =====
// Assertion helpers shared by the skipper RTL.
`ifndef BLANK_AND_COMMENT_SKIPPER_DEFINES_SVH
`define BLANK_AND_COMMENT_SKIPPER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BCS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bcs_pkg.sv =====
`timescale 1ns / 1ps
package bcs_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int LINE_BITS   = 24;

	localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
	localparam logic [LINE_BITS-1:0]   LIN_MAX = '1;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [1:0] OUT_STOP  = 2'd0;
	localparam logic [1:0] OUT_END   = 2'd1;
	localparam logic [1:0] OUT_STRAY = 2'd2;

	typedef enum logic [4:0] {
		MODE_IDLE     = 5'b00001,
		MODE_BLANK    = 5'b00010,
		MODE_LINE     = 5'b00100,
		MODE_BLOCK    = 5'b01000,
		MODE_AFTER_CR = 5'b10000
	} scan_mode_t;

	typedef enum logic [2:0] {
		HELD_NONE  = 3'b001,
		HELD_SLASH = 3'b010,
		HELD_STAR  = 3'b100
	} held_kind_t;

endpackage

// ===== design/blank_and_comment_skipper.sv =====
`timescale 1ns / 1ps
// Skips blanks, newlines, carriage returns and C-style comments in a byte stream taken one
// character per transaction, and reports where the run stops: at a significant character, at
// the NUL that ends the text, or at a stray comment end. A transaction with tuser set starts a
// new run at its character with the line number it carries; characters outside a run are
// dropped. The block takes one character every cycle unless the master side stalls, and a result
// leaves through one input register and one result register, with the whole scan mode update
// done combinationally between them. The result register is only held back by a stalled master
// side, which then stalls the slave side.
`include "blank_and_comment_skipper_defines.svh"
module blank_and_comment_skipper
	import bcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [7:0] ch, [31:8] start_line
	input  logic [0:0]  s_tuser,   // [0] begin_req
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [1:0] outcome, [17:2] stop_offset, [41:18] line_out,
	                               // [47:42] zero
);

	logic                 valid_s1;
	logic [7:0]           ch_s1;
	logic                 begin_s1;
	logic [LINE_BITS-1:0] start_line_s1;

	scan_mode_t             mode_q;
	held_kind_t             held_q;
	logic [OFFSET_BITS-1:0] skip_q;
	logic [LINE_BITS-1:0]   line_q;
	logic                   cje_q;

	logic                   out_valid_q;
	logic [1:0]             outcome_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [LINE_BITS-1:0]   line_out_q;

	logic advance;
	logic process;

	scan_mode_t             eff_mode;
	held_kind_t             eff_held;
	logic [OFFSET_BITS-1:0] eff_skip;
	logic [LINE_BITS-1:0]   eff_line;
	logic                   eff_cje;

	scan_mode_t             mode_d;
	held_kind_t             held_d;
	logic                   cje_d;
	logic [1:0]             inc;
	logic                   line_inc;
	logic                   fin;
	logic [1:0]             outcome_d;
	logic                   run_blank;
	logic [OFFSET_BITS:0]   skip_sum;
	logic [OFFSET_BITS-1:0] skip_d;
	logic [LINE_BITS-1:0]   line_d;

	assign advance  = !out_valid_q || m_tready;
	assign process  = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1         <= s_tdata[7:0];
			start_line_s1 <= s_tdata[31:8];
			begin_s1      <= s_tuser[0];
		end
	end

	// A begin request restarts the run before the character itself is looked at.
	always_comb begin
		if (begin_s1) begin
			eff_mode = MODE_BLANK;
			eff_held = HELD_NONE;
			eff_skip = '0;
			eff_line = start_line_s1;
			eff_cje  = 1'b0;
		end else begin
			eff_mode = mode_q;
			eff_held = held_q;
			eff_skip = skip_q;
			eff_line = line_q;
			eff_cje  = cje_q;
		end
	end

	always_comb begin
		mode_d    = eff_mode;
		held_d    = eff_held;
		cje_d     = eff_cje;
		inc       = 2'd0;
		line_inc  = 1'b0;
		fin       = 1'b0;
		outcome_d = OUT_STOP;
		run_blank = 1'b0;

		unique case (eff_mode)
			MODE_IDLE: begin
			end
			MODE_BLANK: begin
				run_blank = 1'b1;
			end
			MODE_AFTER_CR: begin
				if (ch_s1 == CH_LF) begin
					line_inc = 1'b1;
					inc      = 2'd1;
					mode_d   = MODE_BLANK;
					cje_d    = 1'b0;
				end else if (eff_cje) begin
					// A lone carriage return right after a block comment is just a blank.
					cje_d     = 1'b0;
					mode_d    = MODE_BLANK;
					run_blank = 1'b1;
				end else begin
					fin       = 1'b1;
					outcome_d = (ch_s1 == CH_NUL) ? OUT_END : OUT_STOP;
				end
			end
			MODE_LINE: begin
				if (ch_s1 == CH_NUL) begin
					fin       = 1'b1;
					outcome_d = OUT_END;
				end else if (ch_s1 == CH_LF) begin
					line_inc = 1'b1;
					inc      = 2'd1;
					mode_d   = MODE_BLANK;
				end else begin
					inc = 2'd1;
				end
			end
			MODE_BLOCK: begin
				held_d = HELD_NONE;
				if (eff_held == HELD_STAR && ch_s1 == CH_SLASH) begin
					inc    = 2'd2;
					mode_d = MODE_BLANK;
					cje_d  = 1'b1;
				end else begin
					// A held star that did not close the comment is counted now.
					inc = (eff_held == HELD_STAR) ? 2'd1 : 2'd0;
					if (ch_s1 == CH_NUL) begin
						fin       = 1'b1;
						outcome_d = OUT_END;
					end else if (ch_s1 == CH_STAR) begin
						held_d = HELD_STAR;
					end else begin
						line_inc = (ch_s1 == CH_LF);
						inc      = inc + 2'd1;
					end
				end
			end
			default: begin
			end
		endcase

		if (run_blank) begin
			if (eff_held == HELD_SLASH) begin
				held_d = HELD_NONE;
				if (ch_s1 == CH_SLASH) begin
					inc    = 2'd2;
					mode_d = MODE_LINE;
				end else if (ch_s1 == CH_STAR) begin
					inc    = 2'd2;
					mode_d = MODE_BLOCK;
				end else begin
					fin       = 1'b1;
					outcome_d = OUT_STOP;
				end
			end else if (eff_held == HELD_STAR) begin
				held_d    = HELD_NONE;
				fin       = 1'b1;
				outcome_d = (ch_s1 == CH_SLASH) ? OUT_STRAY : OUT_STOP;
			end else begin
				cje_d = 1'b0;
				if (ch_s1 == CH_SPACE || ch_s1 == CH_TAB) begin
					inc = 2'd1;
				end else if (ch_s1 == CH_SLASH) begin
					held_d = HELD_SLASH;
				end else if (ch_s1 == CH_STAR) begin
					held_d = HELD_STAR;
				end else if (ch_s1 == CH_CR) begin
					inc    = 2'd1;
					mode_d = MODE_AFTER_CR;
					// Coming from a previous carriage return, the comment end is already used up.
					cje_d  = eff_cje && (eff_mode == MODE_BLANK);
				end else if (ch_s1 == CH_LF) begin
					line_inc = 1'b1;
					inc      = 2'd1;
				end else begin
					fin       = 1'b1;
					outcome_d = (ch_s1 == CH_NUL) ? OUT_END : OUT_STOP;
				end
			end
		end

		if (fin) begin
			mode_d = MODE_IDLE;
			held_d = HELD_NONE;
			cje_d  = 1'b0;
		end
	end

	assign skip_sum = {1'b0, eff_skip} + {{(OFFSET_BITS-1){1'b0}}, inc};
	assign skip_d   = skip_sum[OFFSET_BITS] ? OFF_MAX : skip_sum[OFFSET_BITS-1:0];
	assign line_d   = (line_inc && eff_line != LIN_MAX) ? eff_line + 1'b1 : eff_line;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			held_q <= HELD_NONE;
			skip_q <= '0;
			line_q <= '0;
			cje_q  <= 1'b0;
		end else if (process) begin
			mode_q <= mode_d;
			held_q <= held_d;
			skip_q <= skip_d;
			line_q <= line_d;
			cje_q  <= cje_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= process && fin;
		end
	end

	always_ff @(posedge clk) begin
		if (process && fin) begin
			outcome_q  <= outcome_d;
			offset_q   <= skip_d;
			line_out_q <= line_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, line_out_q, offset_q, outcome_q};

	`BCS_ASSERT_SAME(a_held_mode, held_q != HELD_NONE, mode_q == MODE_BLANK || mode_q == MODE_BLOCK, "held character outside blank or block comment mode")
	`BCS_ASSERT_SAME(a_cje_mode, cje_q, mode_q == MODE_BLANK || mode_q == MODE_AFTER_CR, "comment end flag set in wrong mode")
	`BCS_ASSERT_SAME(a_outcome_code, m_tvalid, outcome_q == OUT_STOP || outcome_q == OUT_END || outcome_q == OUT_STRAY, "invalid outcome code")
	`BCS_ASSERT_NEXT(a_fin_idle, process && fin, mode_q == MODE_IDLE && m_tvalid, "finished run did not go idle with a result")

endmodule
